@@ rtl/aeeu_pkg.sv @@
package aeeu_pkg;

  typedef enum logic [3:0] {
    REQ_LINES      = 4'd0,
    REQ_TAKE_INT   = 4'd1,
    REQ_UNDEF      = 4'd2,
    REQ_PABORT     = 4'd3,
    REQ_DABORT     = 4'd4,
    REQ_SWI        = 4'd5,
    REQ_CPSR_WRITE = 4'd6,
    REQ_SPSR_RESTORE = 4'd7,
    REQ_SET_PC     = 4'd8
  } req_e;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1b;
  localparam logic [4:0] MODE_SYS = 5'h1f;

  localparam int unsigned BIT_I = 7;
  localparam int unsigned BIT_F = 6;
  localparam int unsigned BIT_T = 5;

  localparam logic [31:0] FLAGS_MASK = 32'hf800_0000;
  localparam logic [31:0] CTRL_MASK  = 32'h0000_00df;
  localparam logic [31:0] HIGH_BASE  = 32'hffff_0000;
  localparam logic [31:0] RESET_CPSR = 32'h0000_00d3;

  localparam logic [31:0] VEC_UNDEF  = 32'h04;
  localparam logic [31:0] VEC_SWI    = 32'h08;
  localparam logic [31:0] VEC_PABORT = 32'h0c;
  localparam logic [31:0] VEC_DABORT = 32'h10;
  localparam logic [31:0] VEC_IRQ    = 32'h18;
  localparam logic [31:0] VEC_FIQ    = 32'h1c;

  localparam int unsigned NUM_BANKS = 5;
  typedef logic [2:0] bank_t;
  localparam bank_t BANK_FIQ  = 3'd0;
  localparam bank_t BANK_IRQ  = 3'd1;
  localparam bank_t BANK_SVC  = 3'd2;
  localparam bank_t BANK_ABT  = 3'd3;
  localparam bank_t BANK_UND  = 3'd4;
  localparam bank_t BANK_NONE = 3'd5;
  localparam bank_t BANK_BAD  = 3'd6;

  typedef struct packed {
    logic [31:0] new_pc;
    logic [31:0] status_out;
    logic [31:0] link_value;
    logic        link_write;
    logic        irq_pending;
    logic        wake_pulse;
    logic        abort_taken;
    logic        fault;
  } result_t;

  typedef struct packed {
    logic        we;
    bank_t       idx;
    logic [31:0] wdata;
  } spsr_wr_t;

  function automatic bank_t bank_of(logic [4:0] mode);
    bank_t b;
    case (mode)
      MODE_FIQ: b = BANK_FIQ;
      MODE_IRQ: b = BANK_IRQ;
      MODE_SVC: b = BANK_SVC;
      MODE_ABT: b = BANK_ABT;
      MODE_UND: b = BANK_UND;
      MODE_USR, MODE_SYS: b = BANK_NONE;
      default: b = BANK_BAD;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/aeeu_exec.sv @@
module aeeu_exec (
  input  logic [3:0]           req_type_i,
  input  logic                 irq_level_i,
  input  logic                 fiq_level_i,
  input  logic [31:0]          current_pc_i,
  input  logic [31:0]          write_value_i,
  input  logic [3:0]           field_mask_i,
  input  logic                 high_vectors_i,
  input  logic [31:0]          status_i,
  input  logic [31:0]          spsr_rd_i,
  input  logic [1:0]           lines_i,
  input  logic                 pending_i,
  output logic [31:0]          status_o,
  output logic [1:0]           lines_o,
  output aeeu_pkg::spsr_wr_t   spsr_wr_o,
  output aeeu_pkg::result_t    res_o
);
  import aeeu_pkg::*;

  logic        enter;
  logic [4:0]  ent_mode;
  logic [31:0] ent_off;
  logic        ent_set_f;
  logic [31:0] vec_base;
  logic [31:0] ctl_status;
  bank_t       cur_bank;
  bank_t       ent_bank;
  logic        pend;

  assign vec_base = high_vectors_i ? HIGH_BASE : 32'h0;
  assign cur_bank = bank_of(status_i[4:0]);
  assign ent_bank = bank_of(ent_mode);

  always_comb begin
    enter      = 1'b0;
    ent_mode   = MODE_SVC;
    ent_off    = VEC_SWI;
    ent_set_f  = 1'b0;
    ctl_status = status_i;
    lines_o    = lines_i;
    res_o      = '0;
    res_o.new_pc = current_pc_i;
    case (req_e'(req_type_i))
      REQ_LINES: begin
        lines_o = {fiq_level_i, irq_level_i};
      end
      REQ_TAKE_INT: begin
        if (lines_i[1] && !status_i[BIT_F]) begin
          enter = 1'b1; ent_mode = MODE_FIQ; ent_off = VEC_FIQ; ent_set_f = 1'b1;
        end else if (lines_i[0] && !status_i[BIT_I]) begin
          enter = 1'b1; ent_mode = MODE_IRQ; ent_off = VEC_IRQ;
        end else begin
          res_o.fault = 1'b1;
        end
      end
      REQ_UNDEF: begin
        enter = 1'b1; ent_mode = MODE_UND; ent_off = VEC_UNDEF;
      end
      REQ_PABORT: begin
        enter = 1'b1; ent_mode = MODE_ABT; ent_off = VEC_PABORT;
        res_o.abort_taken = 1'b1;
      end
      REQ_DABORT: begin
        enter = 1'b1; ent_mode = MODE_ABT; ent_off = VEC_DABORT;
        res_o.abort_taken = 1'b1;
      end
      REQ_SWI: begin
        enter = 1'b1; ent_mode = MODE_SVC; ent_off = VEC_SWI;
      end
      REQ_CPSR_WRITE: begin
        if (field_mask_i[0] && bank_of(write_value_i[4:0]) == BANK_BAD) begin
          res_o.fault = 1'b1;
        end else begin
          if (field_mask_i[3]) begin
            ctl_status = (ctl_status & ~FLAGS_MASK) | (write_value_i & FLAGS_MASK);
          end
          if (field_mask_i[0]) begin
            ctl_status = (ctl_status & ~CTRL_MASK) | (write_value_i & CTRL_MASK);
          end
        end
      end
      REQ_SPSR_RESTORE: begin
        if (cur_bank != BANK_NONE && cur_bank != BANK_BAD &&
            bank_of(spsr_rd_i[4:0]) != BANK_BAD) begin
          ctl_status = spsr_rd_i;
        end else begin
          res_o.fault = 1'b1;
        end
      end
      REQ_SET_PC: begin
        ctl_status[BIT_T] = write_value_i[0];
        if (write_value_i[0]) begin
          res_o.new_pc = {write_value_i[31:1], 1'b0} + 32'd4;
        end else begin
          res_o.new_pc = write_value_i + 32'd8;
        end
      end
      default: ;
    endcase

    status_o = ctl_status;
    if (enter) begin
      status_o = status_i;
      status_o[4:0]   = ent_mode;
      status_o[BIT_T] = 1'b0;
      status_o[BIT_I] = 1'b1;
      if (ent_set_f) begin
        status_o[BIT_F] = 1'b1;
      end
      res_o.new_pc     = vec_base + ent_off + 32'd8;
      res_o.link_write = 1'b1;
      res_o.link_value = res_o.abort_taken && !(req_e'(req_type_i) == REQ_PABORT)
                         ? current_pc_i : current_pc_i - 32'd4;
    end

    pend = (lines_o[1] && !status_o[BIT_F]) || (lines_o[0] && !status_o[BIT_I]);
    res_o.irq_pending = pend;
    res_o.wake_pulse  = pend && !pending_i;
    res_o.status_out  = status_o;
  end

  assign spsr_wr_o.we    = enter;
  assign spsr_wr_o.idx   = ent_bank;
  assign spsr_wr_o.wdata = status_i;

endmodule

@@ rtl/arm_exception_entry_unit.sv @@
// Results pass through the input register and then the result register; a request leaves
// the input register only when the result register is empty or its result is being taken.
// One request per cycle while the output is not stalled; CPSR, SPSR bank and pending flag
// update as a request leaves the input register, so the next request sees them at once.
// Reset (rst_ni low, asynchronous): CPSR = 0xD3, SPSR bank, line levels, pending
// and high_vectors cleared, both pipeline stages empty.
module arm_exception_entry_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic        irq_level_i,
  input  logic        fiq_level_i,
  input  logic [31:0] current_pc_i,
  input  logic [31:0] write_value_i,
  input  logic [3:0]  field_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_pc_o,
  output logic [31:0] status_out_o,
  output logic [31:0] link_value_o,
  output logic        link_write_o,
  output logic        irq_pending_o,
  output logic        wake_pulse_o,
  output logic        abort_taken_o,
  output logic        fault_o
);
  import aeeu_pkg::*;

  logic        high_vectors_q;
  logic [31:0] status_q, status_d;
  logic [31:0] spsr_q [NUM_BANKS];
  logic [1:0]  lines_q, lines_d;
  logic        pending_q;

  logic        in_valid_q;
  logic [3:0]  req_type_q;
  logic        irq_level_q;
  logic        fiq_level_q;
  logic [31:0] current_pc_q;
  logic [31:0] write_value_q;
  logic [3:0]  field_mask_q;

  logic        out_valid_q;
  result_t     res_q, res_d;
  spsr_wr_t    spsr_wr;
  bank_t       rd_bank;
  logic [31:0] spsr_rd;
  logic        out_free;
  logic        fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // only a valid banked mode reads an SPSR; others read zero and fault anyway
  assign rd_bank = bank_of(status_q[4:0]);
  assign spsr_rd = (rd_bank < BANK_NONE) ? spsr_q[rd_bank[2:0]] : 32'h0;

  aeeu_exec u_exec (
    .req_type_i     (req_type_q),
    .irq_level_i    (irq_level_q),
    .fiq_level_i    (fiq_level_q),
    .current_pc_i   (current_pc_q),
    .write_value_i  (write_value_q),
    .field_mask_i   (field_mask_q),
    .high_vectors_i (high_vectors_q),
    .status_i       (status_q),
    .spsr_rd_i      (spsr_rd),
    .lines_i        (lines_q),
    .pending_i      (pending_q),
    .status_o       (status_d),
    .lines_o        (lines_d),
    .spsr_wr_o      (spsr_wr),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_vectors_q <= 1'b0;
    end else if (cfg_we_i) begin
      high_vectors_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= RESET_CPSR;
      lines_q   <= '0;
      pending_q <= 1'b0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        spsr_q[i] <= '0;
      end
    end else if (fire) begin
      status_q  <= status_d;
      lines_q   <= lines_d;
      pending_q <= res_d.irq_pending;
      if (spsr_wr.we) begin
        spsr_q[spsr_wr.idx] <= spsr_wr.wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q    <= req_type_i;
      irq_level_q   <= irq_level_i;
      fiq_level_q   <= fiq_level_i;
      current_pc_q  <= current_pc_i;
      write_value_q <= write_value_i;
      field_mask_q  <= field_mask_i;
    end
  end

  // hold the result until the transfer; load a new one as the input stage drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_pc_o      = res_q.new_pc;
  assign status_out_o  = res_q.status_out;
  assign link_value_o  = res_q.link_value;
  assign link_write_o  = res_q.link_write;
  assign irq_pending_o = res_q.irq_pending;
  assign wake_pulse_o  = res_q.wake_pulse;
  assign abort_taken_o = res_q.abort_taken;
  assign fault_o       = res_q.fault;

  a_fault_keeps_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.fault |=> $stable(status_q))
    else $error("refused request changed CPSR");

  a_entry_masks_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_write_o |-> status_out_o[BIT_I] && !status_out_o[BIT_T])
    else $error("exception entry left I clear or T set");

  a_wake_implies_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_pulse_o |-> irq_pending_o)
    else $error("wake pulse without pending interrupt");

  a_abort_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && abort_taken_o |-> status_out_o[4:0] == MODE_ABT && link_write_o)
    else $error("abort entered without abort mode");

  a_pending_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> pending_q == res_q.irq_pending)
    else $error("pending flag out of step with result");

endmodule
